@@ rtl/tklock_pkg.sv @@
// Package for the touch keypad code lock: key, event and mode codes,
// key grid bounds and the coordinate-to-key decoder.
// No dependencies.
package tklock_pkg;

    localparam int LOCK_CODE_LEN = 6;

    localparam int X_W      = 10;
    localparam int Y_W      = 9;
    localparam int SECRET_W = 24;
    localparam int MAXF_W   = 3;
    localparam int KEY_W    = 4;
    localparam int EVENT_W  = 4;
    localparam int COUNT_W  = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SECRET_W-1:0] SECRET_RESET = 24'h654321;
    localparam logic [MAXF_W-1:0]   MAXF_RESET   = 3'd3;
    localparam logic [COUNT_W-1:0]  FAIL_SAT     = 3'd7;

    // Configuration register indexes.
    localparam logic REG_SECRET_CODE  = 1'b0;
    localparam logic REG_MAX_FAILURES = 1'b1;

    // Grid bounds; every bound is exclusive on both sides.
    localparam logic [X_W-1:0] COL_EDGE_0 = 10'd0;
    localparam logic [X_W-1:0] COL_EDGE_1 = 10'd266;
    localparam logic [X_W-1:0] COL_EDGE_2 = 10'd533;
    localparam logic [X_W-1:0] COL_EDGE_3 = 10'd800;
    localparam logic [Y_W-1:0] ROW_EDGE_0 = 9'd100;
    localparam logic [Y_W-1:0] ROW_EDGE_1 = 9'd195;
    localparam logic [Y_W-1:0] ROW_EDGE_2 = 9'd290;
    localparam logic [Y_W-1:0] ROW_EDGE_3 = 9'd385;
    localparam logic [Y_W-1:0] ROW_EDGE_4 = 9'd480;

    localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 4'd10;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 4'd11;
    localparam logic [KEY_W-1:0] KEY_NONE      = 4'd15;

    typedef enum logic [EVENT_W-1:0] {
        EV_NO_KEY      = 4'd0,
        EV_DIGIT_TAKEN = 4'd1,
        EV_ENTRY_FULL  = 4'd2,
        EV_DELETED     = 4'd3,
        EV_NOTHING_DEL = 4'd4,
        EV_TOO_FEW     = 4'd5,
        EV_WRONG       = 4'd6,
        EV_LOCKOUT     = 4'd7,
        EV_UNLOCKED    = 4'd8,
        EV_IGNORED     = 4'd9
    } event_t;

    typedef enum logic [1:0] {
        MODE_ENTERING = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_UNLOCKED = 2'd2
    } mode_t;

    // Keys by row from the top: 1 2 3 / 4 5 6 / 7 8 9 / delete 0 enter.
    function automatic logic [KEY_W-1:0] decode_key(input logic [X_W-1:0] x,
                                                    input logic [Y_W-1:0] y);
        logic [1:0] col;
        logic [1:0] row;
        logic       col_ok;
        logic       row_ok;
        logic [KEY_W-1:0] key;
        col_ok = 1'b1;
        row_ok = 1'b1;
        col    = 2'd0;
        row    = 2'd0;
        if (x > COL_EDGE_0 && x < COL_EDGE_1) begin
            col = 2'd0;
        end else if (x > COL_EDGE_1 && x < COL_EDGE_2) begin
            col = 2'd1;
        end else if (x > COL_EDGE_2 && x < COL_EDGE_3) begin
            col = 2'd2;
        end else begin
            col_ok = 1'b0;
        end
        if (y > ROW_EDGE_0 && y < ROW_EDGE_1) begin
            row = 2'd0;
        end else if (y > ROW_EDGE_1 && y < ROW_EDGE_2) begin
            row = 2'd1;
        end else if (y > ROW_EDGE_2 && y < ROW_EDGE_3) begin
            row = 2'd2;
        end else if (y > ROW_EDGE_3 && y < ROW_EDGE_4) begin
            row = 2'd3;
        end else begin
            row_ok = 1'b0;
        end
        if (!(col_ok && row_ok)) begin
            key = KEY_NONE;
        end else if (row == 2'd3) begin
            case (col)
                2'd0:    key = KEY_DELETE;
                2'd1:    key = 4'd0;
                default: key = KEY_ENTER;
            endcase
        end else begin
            key = 4'(({2'b00, row} * 4'd3) + {2'b00, col} + 4'd1);
        end
        return key;
    endfunction

endpackage

@@ rtl/touch_keypad_code_lock.sv @@
// Touch keypad code lock: decodes touch points onto a key grid, collects a
// digit entry and checks it against the configured code. Uses tklock_pkg.
//
//  channel | direction | word contents (lowest bit first)
//  s_      | in        | touch_x[9:0], touch_y[18:10], zero pad to 24 bits
//  m_      | out       | event_res[3:0], key_code[7:4], digits_entered[10:8],
//          |           | failures[13:11], zero pad to 16 bits
//  cfg_    | in        | index 0 secret_code (24 bits), index 1 max_failures
//
// One word is accepted per cycle while a low m_tready does not hold the result;
// the first register holds the decoded key, the second the result, and the
// lock state is updated as a word moves from the first to the second.
// Reset clears the entry count, the failure count and the mode; the stored
// digits are not cleared. When m_tready is low the result holds, one more
// word may wait in the key register, and then s_tready falls.
module touch_keypad_code_lock #(
    parameter int CODE_LEN = tklock_pkg::LOCK_CODE_LEN
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // touch_x [9:0], touch_y [18:10]
    input  logic [tklock_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // event_res [3:0], key_code [7:4], digits_entered [10:8], failures [13:11]
    output logic [tklock_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [tklock_pkg::SECRET_W-1:0]        cfg_wdata
);
    import tklock_pkg::*;

    localparam int CNT_W = $clog2(CODE_LEN + 1);
    localparam int IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam int EXT_W = (CODE_LEN * 4 > SECRET_W) ? CODE_LEN * 4 : SECRET_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CODE_LEN);

    logic [SECRET_W-1:0] secret_reg;
    logic [MAXF_W-1:0]   max_fail_reg;

    logic                key_valid_reg;
    logic [KEY_W-1:0]    key_reg;

    logic [KEY_W-1:0]    digits_reg [CODE_LEN];
    logic [CNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]  fail_reg;
    mode_t               mode_reg;

    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                advance;
    logic [CNT_W-1:0]    count_next;
    logic [COUNT_W-1:0]  fail_next;
    mode_t               mode_next;
    event_t              event_next;
    logic                digit_we;
    logic                match;
    logic [EXT_W-1:0]    code_ext;
    logic [COUNT_W-1:0]  fail_inc;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !key_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_reg   <= SECRET_RESET;
            max_fail_reg <= MAXF_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SECRET_CODE:  secret_reg   <= cfg_wdata;
                REG_MAX_FAILURES: max_fail_reg <= cfg_wdata[MAXF_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            key_valid_reg <= 1'b1;
        end else if (advance) begin
            key_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            key_reg <= decode_key(s_tdata[X_W-1:0], s_tdata[X_W +: Y_W]);
        end
    end

    // Digit compare, all positions in parallel.
    always_comb begin
        code_ext = EXT_W'(secret_reg);
        match    = 1'b1;
        for (int i = 0; i < CODE_LEN; i++) begin
            if (digits_reg[i] != code_ext[4*i +: 4]) begin
                match = 1'b0;
            end
        end
    end

    assign fail_inc = (fail_reg < FAIL_SAT) ? fail_reg + 3'd1 : fail_reg;

    always_comb begin
        count_next = count_reg;
        fail_next  = fail_reg;
        mode_next  = mode_reg;
        event_next = EV_NO_KEY;
        digit_we   = 1'b0;
        if (key_reg == KEY_NONE) begin
            event_next = EV_NO_KEY;
        end else if (mode_reg != MODE_ENTERING) begin
            event_next = EV_IGNORED;
        end else if (key_reg <= KEY_MAX_DIGIT) begin
            if (count_reg >= FULL_COUNT) begin
                event_next = EV_ENTRY_FULL;
            end else begin
                digit_we   = 1'b1;
                count_next = count_reg + CNT_W'(1);
                event_next = EV_DIGIT_TAKEN;
            end
        end else if (key_reg == KEY_DELETE) begin
            if (count_reg == '0) begin
                event_next = EV_NOTHING_DEL;
            end else begin
                count_next = count_reg - CNT_W'(1);
                event_next = EV_DELETED;
            end
        end else begin
            count_next = '0;
            if (count_reg != FULL_COUNT) begin
                event_next = EV_TOO_FEW;
            end else if (match) begin
                mode_next  = MODE_UNLOCKED;
                event_next = EV_UNLOCKED;
            end else begin
                fail_next = fail_inc;
                if (fail_inc >= max_fail_reg) begin
                    mode_next  = MODE_LOCKED;
                    event_next = EV_LOCKOUT;
                end else begin
                    event_next = EV_WRONG;
                end
            end
        end
    end

    // Lock state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            fail_reg      <= '0;
            mode_reg      <= MODE_ENTERING;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= key_valid_reg;
            if (key_valid_reg) begin
                count_reg <= count_next;
                fail_reg  <= fail_next;
                mode_reg  <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && key_valid_reg) begin
            out_data_reg <= {2'b00, fail_next, COUNT_W'(count_next), key_reg,
                             event_next};
            if (digit_we) begin
                digits_reg[count_reg[IDX_W-1:0]] <= key_reg;
            end
        end
    end

endmodule
